[sv/mbdpe_pkg.sv]
// ----------------------------------------------------------------------------
// mbdpe_pkg
// Shared widths, constants and payload types of the button press event block.
// ----------------------------------------------------------------------------
`default_nettype none

package mbdpe_pkg;

   localparam int RAW_W       = 4;
   localparam int TIME_W      = 32;
   localparam int DEBOUNCE_W  = 16;
   localparam int CODE_W      = 5;
   localparam int SEQ_W       = 8;

   localparam int BUTTONS_DEFAULT     = 4;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd35;
   localparam logic [CODE_W-1:0]     CODE_BASE      = 5'h10;

   typedef struct packed {
      logic [RAW_W-1:0]  raw_levels;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] button_code;
      logic [SEQ_W-1:0]  sequence_res;
      logic              last;
   } rsp_type;

   // Queue status seen by the front end and the event generator.
   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

endpackage

`default_nettype wire

[sv/multi_button_debounce_press_events.sv]
// ----------------------------------------------------------------------------
// multi_button_debounce_press_events
// Debounces active-low buttons per poll and emits one event per debounced press.
//
//   Channel | Direction | Payload  | Handshake
//   req_    | in        | req_type | req_valid / req_stall
//   rsp_    | out       | rsp_type | rsp_valid / rsp_stall
//   csr_    | in        | 16 bits  | csr_write, no wait
//
// A poll is debounced in the cycle it is accepted; its press mask waits in a
// QUEUE_DEPTH-entry queue. Events leave one per cycle from an output register
// while rsp_stall is low, so a poll with k presses yields k events in a row.
// req_stall is high only while the queue is full. Reset is synchronous and
// needs no clearing pass; the first event of a poll passes through the queue
// and the output register before it is presented.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_button_debounce_press_events
   import mbdpe_pkg::*;
#(
   parameter int BUTTONS     = BUTTONS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [DEBOUNCE_W-1:0] csr_wdata,
   input  wire logic                  req_valid,
   input  wire req_type               req_data,
   output      logic                  req_stall,
   output      logic                  rsp_valid,
   output      rsp_type               rsp_data,
   input  wire logic                  rsp_stall
);

   logic               push;
   logic [BUTTONS-1:0] push_mask;
   logic               pop;
   queue_status_type   queue_status;
   logic [BUTTONS-1:0] queue_head;

   mbdpe_front #(
      .BUTTONS(BUTTONS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .queue_full(queue_status.full),
      .push      (push),
      .push_mask (push_mask)
   );

   mbdpe_queue #(
      .WIDTH(BUTTONS),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_mask),
      .pop      (pop),
      .status   (queue_status),
      .head     (queue_head)
   );

   mbdpe_back #(
      .BUTTONS(BUTTONS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_status(queue_status),
      .queue_head  (queue_head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .rsp_stall   (rsp_stall)
   );

`ifndef SYNTHESIS
   // A press mask must never be dropped on a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_status.full)
      else $error("press mask pushed into a full queue");

   // Consecutive events carry consecutive sequence numbers.
   a_seq_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=>
         (!rsp_valid || rsp_data.sequence_res == $past(rsp_data.sequence_res) + 8'd1))
      else $error("sequence number skipped");

   // Every event carries a press code.
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.button_code[CODE_W-1])
      else $error("event code below the press code base");

   // The queue is only popped when it holds an entry.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> queue_status.valid)
      else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

[sv/mbdpe_front.sv]
// ----------------------------------------------------------------------------
// mbdpe_front
// Accepts polls, debounces every button in parallel and queues the press mask.
// ----------------------------------------------------------------------------
`default_nettype none

module mbdpe_front
   import mbdpe_pkg::*;
#(
   parameter int BUTTONS = BUTTONS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [DEBOUNCE_W-1:0] csr_wdata,
   input  wire logic                  req_valid,
   input  wire req_type               req_data,
   output      logic                  req_stall,
   input  wire logic                  queue_full,
   output      logic                  push,
   output      logic [BUTTONS-1:0]    push_mask
);

   localparam int NRAW = (BUTTONS < RAW_W) ? BUTTONS : RAW_W;

   logic [DEBOUNCE_W-1:0] debounce_ff, debounce_in;
   logic [BUTTONS-1:0]    sampled_ff, sampled_in;
   logic [BUTTONS-1:0]    stable_ff, stable_in;
   logic [TIME_W-1:0]     change_ff [BUTTONS];
   logic [TIME_W-1:0]     change_in [BUTTONS];
   logic [BUTTONS-1:0]    raw_ext;
   logic [BUTTONS-1:0]    press;
   logic [TIME_W-1:0]     elapsed [BUTTONS];
   logic                  accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      raw_ext = '0;
      for (int i = 0; i < NRAW; i++) begin
         raw_ext[i] = req_data.raw_levels[i];
      end
   end

   // Each button is independent, so all lanes settle in the same cycle.
   always_comb begin
      sampled_in  = sampled_ff;
      stable_in   = stable_ff;
      press       = '0;
      debounce_in = csr_write ? csr_wdata : debounce_ff;
      for (int i = 0; i < BUTTONS; i++) begin
         change_in[i] = change_ff[i];
         if (raw_ext[i] != sampled_ff[i]) begin
            change_in[i] = req_data.now_ms;
         end
         elapsed[i] = req_data.now_ms - change_in[i];
         if (accept) begin
            sampled_in[i] = raw_ext[i];
            if ((stable_ff[i] != raw_ext[i]) &&
                (elapsed[i] >= {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ff})) begin
               stable_in[i] = raw_ext[i];
               press[i]     = !raw_ext[i];
            end
         end else begin
            change_in[i] = change_ff[i];
         end
      end
   end

   assign push      = accept && (press != '0);
   assign push_mask = press;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         sampled_ff  <= '1;
         stable_ff   <= '1;
         for (int i = 0; i < BUTTONS; i++) begin
            change_ff[i] <= '0;
         end
      end else begin
         debounce_ff <= debounce_in;
         sampled_ff  <= sampled_in;
         stable_ff   <= stable_in;
         for (int i = 0; i < BUTTONS; i++) begin
            change_ff[i] <= change_in[i];
         end
      end
   end

endmodule

`default_nettype wire

[sv/mbdpe_queue.sv]
// ----------------------------------------------------------------------------
// mbdpe_queue
// Small first-in first-out queue of press masks between the two halves.
// ----------------------------------------------------------------------------
`default_nettype none

module mbdpe_queue
   import mbdpe_pkg::*;
#(
   parameter int WIDTH = BUTTONS_DEFAULT,
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output      queue_status_type status,
   output      logic [WIDTH-1:0] head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == CW'(DEPTH));
   assign head         = entry_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && status.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[sv/mbdpe_back.sv]
// ----------------------------------------------------------------------------
// mbdpe_back
// Turns queued press masks into press events, lowest button first.
// ----------------------------------------------------------------------------
`default_nettype none

module mbdpe_back
   import mbdpe_pkg::*;
#(
   parameter int BUTTONS = BUTTONS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire queue_status_type   queue_status,
   input  wire logic [BUTTONS-1:0] queue_head,
   output      logic               pop,
   output      logic               rsp_valid,
   output      rsp_type            rsp_data,
   input  wire logic               rsp_stall
);

   localparam int IW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

   logic [BUTTONS-1:0] pend_ff, pend_in;
   logic [SEQ_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [BUTTONS-1:0] cur;
   logic [BUTTONS-1:0] rest;
   logic [IW-1:0]      idx;
   logic               advance;
   logic               emit;

   assign cur = (pend_ff != '0) ? pend_ff : (queue_status.valid ? queue_head : '0);

   always_comb begin
      idx = '0;
      for (int i = BUTTONS - 1; i >= 0; i--) begin
         if (cur[i]) begin
            idx = IW'(i);
         end
      end
   end

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign emit    = advance && (cur != '0);
   assign pop     = emit && (pend_ff == '0);

   always_comb begin
      rest = cur;
      rest[idx] = 1'b0;
      pend_in      = pend_ff;
      count_in     = count_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         pend_in                  = rest;
         count_in                 = count_ff + 1'b1;
         rsp_data_in.button_code  = CODE_BASE + CODE_W'(idx);
         rsp_data_in.sequence_res = count_ff;
         rsp_data_in.last         = (rest == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the button debouncer that emits press events.
//
// A directed table walks releases, presses, bounce, timestamp wrap, zero and
// maximum debounce times and all four buttons at once, with the result count
// and first event of each poll typed in. Random phases then run sequences of
// held levels over advancing timestamps, each phase under a debounce time
// and idling pattern set for it. Every result transaction is checked field by field
// against a predictor that tracks sampled and stable levels, change times and
// the press sequence number.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mbdpe_pkg::*;

   localparam int NUM_BUTTONS   = BUTTONS_DEFAULT;
   localparam int SETTLE_CYCLES = 10;
   localparam int PHASE_POLLS   = 22;
   localparam int NUM_PHASES    = 5;
   localparam int LONG_HOLD     = 120;

   typedef enum logic {ROW_POLL, ROW_CFG} row_kind_type;

   // What a directed row says about its own poll: event count, first event.
   typedef struct packed {
      logic              known;
      logic [2:0]        n;
      logic [CODE_W-1:0] code;
      logic [SEQ_W-1:0]  seq;
   } poll_note_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [RAW_W-1:0]      raw;
      logic [TIME_W-1:0]     now;
      logic [DEBOUNCE_W-1:0] cfg;
      logic                  known;
      logic [2:0]            n;
      logic [CODE_W-1:0]     code;
      logic [SEQ_W-1:0]      seq;
   } dir_row_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  csr_write = 1'b0;
   logic [DEBOUNCE_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   req_type               req_data  = '0;
   logic                  req_stall;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  rsp_stall = 1'b0;

   // Predictor state.
   logic [RAW_W-1:0]      sampled_lv   = '1;
   logic [RAW_W-1:0]      stable_lv    = '1;
   logic [TIME_W-1:0]     change_ms [NUM_BUTTONS];
   logic [SEQ_W-1:0]      press_seq    = '0;
   logic [DEBOUNCE_W-1:0] debounce_set = DEBOUNCE_RESET;

   rsp_type       pending_presses [$];
   poll_note_type poll_notes [$];
   int            mismatch_count = 0;
   int            tx_gap_max     = 18;
   int            rx_gap_max     = 18;
   int            rx_hold_cycles = 0;

   dir_row_type directed_rows [24] = '{
      '{ROW_POLL, 4'hF, 32'h0000_0000, 16'h0000, 1'b1, 3'd0, 5'h00,     8'd0},
      '{ROW_POLL, 4'hE, 32'h0000_0064, 16'h0000, 1'b1, 3'd0, 5'h00,     8'd0},
      '{ROW_POLL, 4'hE, 32'h0000_0086, 16'h0000, 1'b1, 3'd0, 5'h00,     8'd0},
      '{ROW_POLL, 4'hE, 32'h0000_0087, 16'h0000, 1'b1, 3'd1, CODE_BASE, 8'd0},
      '{ROW_POLL, 4'hF, 32'h0000_0088, 16'h0000, 1'b1, 3'd0, 5'h00,     8'd0},
      '{ROW_POLL, 4'hF, 32'h0000_00AB, 16'h0000, 1'b1, 3'd0, 5'h00,     8'd0},
      '{ROW_POLL, 4'h0, 32'h0000_00C8, 16'h0000, 1'b1, 3'd0, 5'h00,     8'd0},
      '{ROW_POLL, 4'h0, 32'h0000_00EB, 16'h0000, 1'b1, 3'd4, CODE_BASE, 8'd1},
      '{ROW_POLL, 4'hF, 32'hFFFF_FFF0, 16'h0000, 1'b1, 3'd0, 5'h00,     8'd0},
      '{ROW_POLL, 4'hF, 32'h0000_0013, 16'h0000, 1'b1, 3'd0, 5'h00,     8'd0},
      '{ROW_POLL, 4'h5, 32'h0000_0013, 16'h0000, 1'b1, 3'd0, 5'h00,     8'd0},
      '{ROW_POLL, 4'hD, 32'h0000_0020, 16'h0000, 1'b1, 3'd0, 5'h00,     8'd0},
      '{ROW_POLL, 4'hD, 32'h0000_0036, 16'h0000, 1'b1, 3'd1, CODE_W'(CODE_BASE + 1), 8'd5},
      '{ROW_CFG,  4'hF, 32'h0000_0000, 16'h0000, 1'b0, 3'd0, 5'h00,     8'd0},
      '{ROW_POLL, 4'h5, 32'h0000_0040, 16'h0000, 1'b1, 3'd1, CODE_W'(CODE_BASE + 3), 8'd6},
      '{ROW_POLL, 4'hF, 32'h0000_0040, 16'h0000, 1'b1, 3'd0, 5'h00,     8'd0},
      '{ROW_POLL, 4'h0, 32'h0000_0041, 16'h0000, 1'b1, 3'd4, CODE_BASE, 8'd7},
      '{ROW_POLL, 4'hF, 32'h0000_0041, 16'h0000, 1'b1, 3'd0, 5'h00,     8'd0},
      '{ROW_CFG,  4'hF, 32'h0000_0000, 16'hFFFF, 1'b0, 3'd0, 5'h00,     8'd0},
      '{ROW_POLL, 4'hB, 32'h0000_1000, 16'h0000, 1'b1, 3'd0, 5'h00,     8'd0},
      '{ROW_POLL, 4'hB, 32'h0001_0FFE, 16'h0000, 1'b1, 3'd0, 5'h00,     8'd0},
      '{ROW_POLL, 4'hB, 32'h0001_0FFF, 16'h0000, 1'b1, 3'd1, CODE_W'(CODE_BASE + 2), 8'd11},
      '{ROW_POLL, 4'hF, 32'h0001_1000, 16'h0000, 1'b1, 3'd0, 5'h00,     8'd0},
      '{ROW_POLL, 4'hF, 32'hFFFF_FFFF, 16'h0000, 1'b1, 3'd0, 5'h00,     8'd0}
   };

   multi_button_debounce_press_events dut (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("FAILED: results differ");
      $finish;
   end

   // Debounces one poll and queues the press events it causes.
   function automatic void debounce_poll(input req_type poll);
      rsp_type          found [$];
      rsp_type          ev;
      logic [TIME_W-1:0] elapsed;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         if (poll.raw_levels[b] != sampled_lv[b]) begin
            sampled_lv[b] = poll.raw_levels[b];
            change_ms[b]  = poll.now_ms;
         end
         elapsed = poll.now_ms - change_ms[b];
         if (stable_lv[b] != sampled_lv[b] && elapsed >= TIME_W'(debounce_set)) begin
            stable_lv[b] = sampled_lv[b];
            if (!stable_lv[b]) begin
               ev.button_code  = CODE_BASE + CODE_W'(b);
               ev.sequence_res = press_seq;
               ev.last         = 1'b0;
               found.push_back(ev);
               press_seq = press_seq + 1'b1;
            end
         end
      end
      if (found.size() > 0) found[found.size() - 1].last = 1'b1;
      foreach (found[i]) pending_presses.push_back(found[i]);
   endfunction

   task automatic send_poll(input logic [RAW_W-1:0] raw, input logic [TIME_W-1:0] now,
                            input poll_note_type note);
      int gap;
      gap = $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      poll_notes.push_back(note);
      req_valid <= 1'b1;
      req_data  <= '{raw_levels: raw, now_ms: now};
      do @(posedge clock); while (req_stall);
   endtask

   // Waits until every expected event has arrived and the block has settled.
   task automatic drain_events();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_presses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_debounce(input logic [DEBOUNCE_W-1:0] value);
      csr_write    <= 1'b1;
      csr_wdata    <= value;
      debounce_set = value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin : stimulus
      poll_note_type         note;
      logic [RAW_W-1:0]      cur_raw;
      logic [TIME_W-1:0]     cur_ms;
      logic [DEBOUNCE_W-1:0] phase_debounce [NUM_PHASES];
      int                    deb;
      int                    pick;
      foreach (change_ms[i]) change_ms[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CFG) begin
            drain_events();
            write_debounce(directed_rows[r].cfg);
         end else begin
            note = '{directed_rows[r].known, directed_rows[r].n,
                     directed_rows[r].code, directed_rows[r].seq};
            send_poll(directed_rows[r].raw, directed_rows[r].now, note);
         end
      end

      phase_debounce = '{16'd20, 16'd0, 16'hFFFF, 16'($urandom_range(1, 60)), 16'd7};
      cur_raw = '1;
      cur_ms  = $urandom;
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_events();
         write_debounce(phase_debounce[p]);
         deb = int'(phase_debounce[p]);
         case (p)
            0: begin tx_gap_max = 18; rx_gap_max = 18; end
            1: begin
               // No idling, and the receiver holds off so the press-mask queue fills.
               tx_gap_max     = 0;
               rx_gap_max     = 0;
               rx_hold_cycles = LONG_HOLD;
            end
            2: begin tx_gap_max = 3;  rx_gap_max = 18; end
            3: begin tx_gap_max = 18; rx_gap_max = 0;  end
            default: begin tx_gap_max = 18; rx_gap_max = 18; end
         endcase
         for (int k = 0; k < PHASE_POLLS; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
               // Noise: unrelated levels and time.
               cur_raw = 4'($urandom);
               cur_ms  = $urandom;
            end else begin
               if ($urandom_range(0, 3) == 0) cur_raw ^= 4'($urandom_range(1, 15));
               pick = $urandom_range(0, 9);
               if (pick < 5)      cur_ms += $urandom_range(0, deb / 3 + 2);
               else if (pick < 7) cur_ms += deb + $urandom_range(0, 2) - 1;
               else if (pick < 9) cur_ms += $urandom_range(0, 2 * deb + 4);
               else               cur_ms += $urandom;
            end
            send_poll(cur_raw, cur_ms, '0);
         end
      end

      drain_events();
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin : result_sink
      int hold;
      forever begin
         hold = $urandom_range(0, rx_gap_max);
         if (rx_hold_cycles > 0) begin
            hold           = rx_hold_cycles;
            rx_hold_cycles = 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin : scoreboard
      int            first_idx;
      int            produced;
      poll_note_type note;
      rsp_type       want;
      if (!reset && req_valid && !req_stall) begin
         first_idx = pending_presses.size();
         note      = poll_notes.pop_front();
         debounce_poll(req_data);
         produced = pending_presses.size() - first_idx;
         if (note.known) begin
            if (produced != int'(note.n)) begin
               $error("event count: expected %0d, actual %0d", note.n, produced);
               mismatch_count++;
            end else if (produced > 0 &&
                         (pending_presses[first_idx].button_code != note.code ||
                          pending_presses[first_idx].sequence_res != note.seq)) begin
               $error("first event: expected code %0h seq %0d, actual code %0h seq %0d",
                      note.code, note.seq, pending_presses[first_idx].button_code,
                      pending_presses[first_idx].sequence_res);
               mismatch_count++;
            end
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_presses.size() == 0) begin
            $error("unexpected press event: button_code %0h sequence_res %0d",
                   rsp_data.button_code, rsp_data.sequence_res);
            mismatch_count++;
         end else begin
            want = pending_presses.pop_front();
            if (rsp_data.button_code !== want.button_code) begin
               $error("button_code: expected %0h, actual %0h",
                      want.button_code, rsp_data.button_code);
               mismatch_count++;
            end
            if (rsp_data.sequence_res !== want.sequence_res) begin
               $error("sequence_res: expected %0d, actual %0d",
                      want.sequence_res, rsp_data.sequence_res);
               mismatch_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_data.last);
               mismatch_count++;
            end
         end
      end
   end

endmodule

`default_nettype wire
